/* rtl/ffc_pkg.sv */
`timescale 1ns / 1ps

package ffc_pkg;

    // Field and datapath widths. Coordinates are signed Q16.16, axes signed Q2.30.
    localparam int COORD_W = 32;
    localparam int AXIS_W  = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SUM_W   = COORD_W + 2;
    localparam int FAC_W   = 31;
    localparam int VEC_W   = 62;
    localparam int MAG_W   = 30;
    localparam int SQ_W    = 62;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = ROOT_W + 3;
    localparam int QUO_W   = 31;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int POS_W   = 6;
    localparam int TOP_BIT = MAG_W - 1;

    // Pipeline depths.
    localparam int FRONT_STAGES = 3;
    localparam int NORM_STAGES  = 5 + ROOT_W + QUO_W + 1;
    localparam int CENTER_DLY   = FRONT_STAGES + NORM_STAGES;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctrl_t;

endpackage

/* rtl/ffc_unit_norm.sv */
`timescale 1ns / 1ps

module ffc_unit_norm import ffc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pipe_ctrl_t ctrl,
    input  vec_t       vec_in [3],
    output logic       valid_out,
    output axis_t      comp_out [3]
);

    // Stage 1: sign and magnitude, largest magnitude.
    logic [VEC_W-1:0] m1_mag_next [3];
    logic [VEC_W-1:0] m1_max_next;
    logic [VEC_W-1:0] m1_mag_reg [3];
    logic [VEC_W-1:0] m1_max_reg;
    logic [2:0]       m1_neg_reg;
    logic             m1_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            m1_mag_next[c] = vec_in[c][VEC_W-1] ? (~vec_in[c] + 1'b1) : vec_in[c];
        end
        m1_max_next = m1_mag_next[0];
        if (m1_mag_next[1] > m1_max_next)
        begin
            m1_max_next = m1_mag_next[1];
        end
        if (m1_mag_next[2] > m1_max_next)
        begin
            m1_max_next = m1_mag_next[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            m1_mag_reg <= m1_mag_next;
            m1_max_reg <= m1_max_next;
            for (int c = 0; c < 3; c++)
            begin
                m1_neg_reg[c] <= vec_in[c][VEC_W-1];
            end
        end
    end

    // Stage 2: position of the leading one of the largest magnitude.
    logic [POS_W-1:0] m2_pos_next;
    logic [POS_W-1:0] m2_pos_reg;
    logic [VEC_W-1:0] m2_mag_reg [3];
    logic [2:0]       m2_neg_reg;
    logic             m2_zero_reg;
    logic             m2_valid_reg;

    always_comb
    begin
        m2_pos_next = '0;
        for (int i = 0; i < VEC_W; i++)
        begin
            if (m1_max_reg[i])
            begin
                m2_pos_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            m2_pos_reg  <= m2_pos_next;
            m2_mag_reg  <= m1_mag_reg;
            m2_neg_reg  <= m1_neg_reg;
            m2_zero_reg <= (m1_max_reg == '0);
        end
    end

    // Stage 3: common block shift so that the largest has its top bit at TOP_BIT.
    logic [MAG_W-1:0] m3_mag_next [3];
    logic [MAG_W-1:0] m3_mag_reg [3];
    logic [2:0]       m3_neg_reg;
    logic             m3_zero_reg;
    logic             m3_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (m2_pos_reg >= POS_W'(TOP_BIT))
            begin
                m3_mag_next[c] = MAG_W'(m2_mag_reg[c] >> (m2_pos_reg - POS_W'(TOP_BIT)));
            end
            else
            begin
                m3_mag_next[c] = MAG_W'(m2_mag_reg[c] << (POS_W'(TOP_BIT) - m2_pos_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            m3_mag_reg  <= m3_mag_next;
            m3_neg_reg  <= m2_neg_reg;
            m3_zero_reg <= m2_zero_reg;
        end
    end

    // Stage 4: squares.
    logic [2*MAG_W-1:0] m4_sq_reg [3];
    logic [MAG_W-1:0]   m4_mag_reg [3];
    logic [2:0]         m4_neg_reg;
    logic               m4_zero_reg;
    logic               m4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m4_sq_reg[c] <= m3_mag_reg[c] * m3_mag_reg[c];
            end
            m4_mag_reg  <= m3_mag_reg;
            m4_neg_reg  <= m3_neg_reg;
            m4_zero_reg <= m3_zero_reg;
        end
    end

    // Stage 5: squared length.
    logic [SQ_W-1:0]  m5_n_reg;
    logic [MAG_W-1:0] m5_mag_reg [3];
    logic [2:0]       m5_neg_reg;
    logic             m5_zero_reg;
    logic             m5_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            m5_n_reg    <= SQ_W'(m4_sq_reg[0]) + SQ_W'(m4_sq_reg[1]) + SQ_W'(m4_sq_reg[2]);
            m5_mag_reg  <= m4_mag_reg;
            m5_neg_reg  <= m4_neg_reg;
            m5_zero_reg <= m4_zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            m4_valid_reg <= 1'b0;
            m5_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            m1_valid_reg <= ctrl.valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            m4_valid_reg <= m3_valid_reg;
            m5_valid_reg <= m4_valid_reg;
        end
    end

    // Square root, one result bit per stage.
    logic [SQ_W-1:0]   s_n_reg    [ROOT_W];
    logic [REM_W-1:0]  s_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] s_root_reg [ROOT_W];
    logic [MAG_W-1:0]  s_mag_reg  [ROOT_W][3];
    logic [2:0]        s_neg_reg  [ROOT_W];
    logic              s_zero_reg [ROOT_W];
    logic              s_valid_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int J = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   n_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [MAG_W-1:0]  mag_in [3];
        logic [2:0]        neg_in;
        logic              zero_in;
        logic              valid_in;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_src
            always_comb
            begin
                n_in     = m5_n_reg;
                rem_in   = '0;
                root_in  = '0;
                mag_in   = m5_mag_reg;
                neg_in   = m5_neg_reg;
                zero_in  = m5_zero_reg;
                valid_in = m5_valid_reg;
            end
        end
        else
        begin : g_src
            always_comb
            begin
                n_in     = s_n_reg[k-1];
                rem_in   = s_rem_reg[k-1];
                root_in  = s_root_reg[k-1];
                mag_in   = s_mag_reg[k-1];
                neg_in   = s_neg_reg[k-1];
                zero_in  = s_zero_reg[k-1];
                valid_in = s_valid_reg[k-1];
            end
        end

        always_comb
        begin
            cur   = {rem_in[REM_W-3:0], n_in[2*J+1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                s_n_reg[k]    <= n_in;
                s_rem_reg[k]  <= rem_next;
                s_root_reg[k] <= root_next;
                s_mag_reg[k]  <= mag_in;
                s_neg_reg[k]  <= neg_in;
                s_zero_reg[k] <= zero_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s_valid_reg[k] <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                s_valid_reg[k] <= valid_in;
            end
        end
    end

    // Division, one quotient bit per stage for all three components.
    // The dividend is mag * 2^30 + floor(r / 2); its bits are fed in as needed.
    // Only the first stage still needs a bit of mag; the rest come from r.
    logic [DREM_W-1:0] d_rem_reg  [QUO_W][3];
    logic [QUO_W-1:0]  d_quo_reg  [QUO_W][3];
    logic [ROOT_W-1:0] d_root_reg [QUO_W];
    logic [2:0]        d_neg_reg  [QUO_W];
    logic              d_zero_reg [QUO_W];
    logic              d_valid_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int I = QUO_W - 1 - k;
        logic [DREM_W-1:0] rem_in [3];
        logic [QUO_W-1:0]  quo_in [3];
        logic [ROOT_W-1:0] root_in;
        logic [2:0]        neg_in;
        logic              zero_in;
        logic              valid_in;
        logic [2:0]        nbit;
        logic [DREM_W-1:0] cur [3];
        logic [DREM_W-1:0] rem_next [3];
        logic [QUO_W-1:0]  quo_next [3];

        if (k == 0)
        begin : g_src
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c] = DREM_W'(s_mag_reg[ROOT_W-1][c][MAG_W-1:1]);
                    quo_in[c] = '0;
                end
                root_in  = s_root_reg[ROOT_W-1];
                neg_in   = s_neg_reg[ROOT_W-1];
                zero_in  = s_zero_reg[ROOT_W-1];
                valid_in = s_valid_reg[ROOT_W-1];
            end
        end
        else
        begin : g_src
            always_comb
            begin
                rem_in   = d_rem_reg[k-1];
                quo_in   = d_quo_reg[k-1];
                root_in  = d_root_reg[k-1];
                neg_in   = d_neg_reg[k-1];
                zero_in  = d_zero_reg[k-1];
                valid_in = d_valid_reg[k-1];
            end
        end

        if (I >= MAG_W)
        begin : g_bit
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    nbit[c] = s_mag_reg[ROOT_W-1][c][I-MAG_W];
                end
            end
        end
        else
        begin : g_bit
            assign nbit = {3{root_in[I+1]}};
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                cur[c] = {rem_in[c][DREM_W-2:0], nbit[c]};
                if (cur[c] >= {1'b0, root_in})
                begin
                    rem_next[c] = cur[c] - {1'b0, root_in};
                    quo_next[c] = {quo_in[c][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = cur[c];
                    quo_next[c] = {quo_in[c][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.advance)
            begin
                d_rem_reg[k]  <= rem_next;
                d_quo_reg[k]  <= quo_next;
                d_root_reg[k] <= root_in;
                d_neg_reg[k]  <= neg_in;
                d_zero_reg[k] <= zero_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_valid_reg[k] <= 1'b0;
            end
            else if (ctrl.advance)
            begin
                d_valid_reg[k] <= valid_in;
            end
        end
    end

    // Final stage: apply signs; a zero-length vector gives the zero vector.
    axis_t comp_next [3];
    axis_t comp_reg  [3];
    logic  f_valid_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (d_zero_reg[QUO_W-1])
            begin
                comp_next[c] = '0;
            end
            else if (d_neg_reg[QUO_W-1][c])
            begin
                comp_next[c] = -$signed({1'b0, d_quo_reg[QUO_W-1][c]});
            end
            else
            begin
                comp_next[c] = $signed({1'b0, d_quo_reg[QUO_W-1][c]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            comp_reg <= comp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            f_valid_reg <= d_valid_reg[QUO_W-1];
        end
    end

    assign valid_out = f_valid_reg;
    assign comp_out  = comp_reg;

endmodule

/* rtl/frame_from_four_corners.sv */
`timescale 1ns / 1ps

// Builds a local frame from four measured corners of a quadrilateral.
// Input channel: in_valid, in_stall and twelve signed Q16.16 coordinates. A
// request is taken at a rising edge where in_valid is high and in_stall low.
// Output channel: out_valid, out_stall, three unit axes u, v, w in signed Q2.30
// and the centre of the corners in Q16.16. A request leaves at an edge where
// out_valid is high and out_stall low.
// Each request gives exactly one result. It passes through one register
// per stage: four front stages, five normalising stages, 31 square root
// stages and 31 division stages that each resolve one bit, and a final
// sign stage. The pipeline takes a new request every cycle while it is
// not held by a stall; throughput is one per cycle while it does not stall.
// When the receiver stalls while a result waits, the whole pipeline holds
// and in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit, so the block comes out of reset empty and
// ready; no clearing pass is needed.
module frame_from_four_corners import ffc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] c0_x,
    input  logic signed [COORD_W-1:0] c0_y,
    input  logic signed [COORD_W-1:0] c0_z,
    input  logic signed [COORD_W-1:0] c1_x,
    input  logic signed [COORD_W-1:0] c1_y,
    input  logic signed [COORD_W-1:0] c1_z,
    input  logic signed [COORD_W-1:0] c2_x,
    input  logic signed [COORD_W-1:0] c2_y,
    input  logic signed [COORD_W-1:0] c2_z,
    input  logic signed [COORD_W-1:0] c3_x,
    input  logic signed [COORD_W-1:0] c3_y,
    input  logic signed [COORD_W-1:0] c3_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [AXIS_W-1:0]  axis_u_x,
    output logic signed [AXIS_W-1:0]  axis_u_y,
    output logic signed [AXIS_W-1:0]  axis_u_z,
    output logic signed [AXIS_W-1:0]  axis_v_x,
    output logic signed [AXIS_W-1:0]  axis_v_y,
    output logic signed [AXIS_W-1:0]  axis_v_z,
    output logic signed [AXIS_W-1:0]  axis_w_x,
    output logic signed [AXIS_W-1:0]  axis_w_y,
    output logic signed [AXIS_W-1:0]  axis_w_z,
    output logic signed [COORD_W-1:0] center_x,
    output logic signed [COORD_W-1:0] center_y,
    output logic signed [COORD_W-1:0] center_z
);

    // The pipeline moves as one whole; it holds only when a finished result
    // is refused by the receiver.
    logic       advance;
    pipe_ctrl_t ctrl;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    logic [COORD_W-1:0] c [4][3];

    assign c[0] = '{c0_x, c0_y, c0_z};
    assign c[1] = '{c1_x, c1_y, c1_z};
    assign c[2] = '{c2_x, c2_y, c2_z};
    assign c[3] = '{c3_x, c3_y, c3_z};

    // Stage 1: diagonals, their sum and difference, and the centre. All sums
    // are held at full width, so nothing can overflow.
    logic signed [DIFF_W-1:0]  d1_next [3];
    logic signed [DIFF_W-1:0]  d2_next [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic signed [DIFF_W-1:0]  d1_reg [3];
    logic signed [DIFF_W-1:0]  d2_reg [3];
    logic signed [SUM_W-1:0]   u_reg [3];
    logic signed [SUM_W-1:0]   w_reg [3];
    logic signed [COORD_W-1:0] mean_reg [3];
    logic                      s1_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = {c[2][i][COORD_W-1], c[2][i]} - {c[0][i][COORD_W-1], c[0][i]};
            d2_next[i] = {c[3][i][COORD_W-1], c[3][i]} - {c[1][i][COORD_W-1], c[1][i]};
            sum_next[i] = {{2{c[0][i][COORD_W-1]}}, c[0][i]}
                        + {{2{c[1][i][COORD_W-1]}}, c[1][i]}
                        + {{2{c[2][i][COORD_W-1]}}, c[2][i]}
                        + {{2{c[3][i][COORD_W-1]}}, c[3][i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]   <= d1_next[i];
                d2_reg[i]   <= d2_next[i];
                u_reg[i]    <= {d1_next[i][DIFF_W-1], d1_next[i]}
                             + {d2_next[i][DIFF_W-1], d2_next[i]};
                w_reg[i]    <= {d1_next[i][DIFF_W-1], d1_next[i]}
                             - {d2_next[i][DIFF_W-1], d2_next[i]};
                // Dropping the two low bits rounds the mean toward minus infinity.
                mean_reg[i] <= sum_next[i][SUM_W-1:2];
            end
        end
    end

    // Stage 2: the six diagonal components are scaled by one common right
    // shift so that every factor of the cross product stays below 2^30.
    logic [DIFF_W-1:0]        dmag [6];
    logic [5:0]               dneg;
    logic [DIFF_W-1:0]        dmax;
    logic [1:0]               dshift;
    logic [MAG_W-1:0]         fmag [6];
    logic signed [FAC_W-1:0]  fac_reg [6];
    logic                     s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dneg[i]     = d1_reg[i][DIFF_W-1];
            dneg[i + 3] = d2_reg[i][DIFF_W-1];
            dmag[i]     = dneg[i] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
            dmag[i + 3] = dneg[i + 3] ? (~d2_reg[i] + 1'b1) : d2_reg[i];
        end
        // The OR of the magnitudes has the same leading one as the largest.
        dmax = dmag[0];
        for (int i = 1; i < 6; i++)
        begin
            dmax = dmax | dmag[i];
        end
        if (dmax[DIFF_W-1])
        begin
            dshift = 2'd3;
        end
        else if (dmax[DIFF_W-2])
        begin
            dshift = 2'd2;
        end
        else if (dmax[DIFF_W-3])
        begin
            dshift = 2'd1;
        end
        else
        begin
            dshift = 2'd0;
        end
        for (int i = 0; i < 6; i++)
        begin
            fmag[i] = MAG_W'(dmag[i] >> dshift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 6; i++)
            begin
                fac_reg[i] <= dneg[i] ? -$signed({1'b0, fmag[i]}) : $signed({1'b0, fmag[i]});
            end
        end
    end

    // Stage 3: the six partial products of d1 x d2 (factors a = 0..2, b = 3..5).
    vec_t prod_reg [6];
    logic s3_valid_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg[0] <= fac_reg[1] * fac_reg[5];
            prod_reg[1] <= fac_reg[2] * fac_reg[4];
            prod_reg[2] <= fac_reg[2] * fac_reg[3];
            prod_reg[3] <= fac_reg[0] * fac_reg[5];
            prod_reg[4] <= fac_reg[0] * fac_reg[4];
            prod_reg[5] <= fac_reg[1] * fac_reg[3];
        end
    end

    // Stage 4: the cross product, which points along v.
    vec_t cross_reg [3];
    logic s4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= prod_reg[2 * i] - prod_reg[2 * i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // u and w wait for the cross product; the centre waits for the axes.
    logic signed [SUM_W-1:0]   u_dly_reg [FRONT_STAGES][3];
    logic signed [SUM_W-1:0]   w_dly_reg [FRONT_STAGES][3];
    logic signed [COORD_W-1:0] center_dly_reg [CENTER_DLY][3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u_dly_reg[0] <= u_reg;
            w_dly_reg[0] <= w_reg;
            for (int t = 1; t < FRONT_STAGES; t++)
            begin
                u_dly_reg[t] <= u_dly_reg[t-1];
                w_dly_reg[t] <= w_dly_reg[t-1];
            end
            center_dly_reg[0] <= mean_reg;
            for (int t = 1; t < CENTER_DLY; t++)
            begin
                center_dly_reg[t] <= center_dly_reg[t-1];
            end
        end
    end

    vec_t  u_vec [3];
    vec_t  w_vec [3];
    axis_t u_axis [3];
    axis_t v_axis [3];
    axis_t w_axis [3];
    logic  u_valid;
    logic  v_valid;
    logic  w_valid;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_vec[i] = VEC_W'(u_dly_reg[FRONT_STAGES-1][i]);
            w_vec[i] = VEC_W'(w_dly_reg[FRONT_STAGES-1][i]);
        end
    end

    assign ctrl.advance = advance;
    assign ctrl.valid   = s4_valid_reg;

    ffc_unit_norm u_norm_u
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .vec_in    (u_vec),
        .valid_out (u_valid),
        .comp_out  (u_axis)
    );

    ffc_unit_norm u_norm_v
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .vec_in    (cross_reg),
        .valid_out (v_valid),
        .comp_out  (v_axis)
    );

    ffc_unit_norm u_norm_w
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .vec_in    (w_vec),
        .valid_out (w_valid),
        .comp_out  (w_axis)
    );

    assign out_valid = u_valid;
    assign axis_u_x  = u_axis[0];
    assign axis_u_y  = u_axis[1];
    assign axis_u_z  = u_axis[2];
    assign axis_v_x  = v_axis[0];
    assign axis_v_y  = v_axis[1];
    assign axis_v_z  = v_axis[2];
    assign axis_w_x  = w_axis[0];
    assign axis_w_y  = w_axis[1];
    assign axis_w_z  = w_axis[2];
    assign center_x  = center_dly_reg[CENTER_DLY-1][0];
    assign center_y  = center_dly_reg[CENTER_DLY-1][1];
    assign center_z  = center_dly_reg[CENTER_DLY-1][2];

    // The three normalisers share one enable, so their valid bits must agree.
    a_valid_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (u_valid == v_valid) && (v_valid == w_valid))
        else $error("normaliser valid bits disagree");

    // A unit axis component never exceeds one in magnitude.
    a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_u_x <= 32'sd1073741824) && (axis_u_x >= -32'sd1073741824)
                   && (axis_u_y <= 32'sd1073741824) && (axis_u_y >= -32'sd1073741824)
                   && (axis_u_z <= 32'sd1073741824) && (axis_u_z >= -32'sd1073741824))
        else $error("axis u out of range");

    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_w_x <= 32'sd1073741824) && (axis_w_x >= -32'sd1073741824)
                   && (axis_w_y <= 32'sd1073741824) && (axis_w_y >= -32'sd1073741824)
                   && (axis_w_z <= 32'sd1073741824) && (axis_w_z >= -32'sd1073741824))
        else $error("axis w out of range");

endmodule
